>>> hw/rtl/pce_pkg.sv
// Shared types and constants for the polyline coordinate encoder.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package pce_pkg;

  localparam int unsigned LAT_W  = 25;
  localparam int unsigned LNG_W  = 26;
  localparam int unsigned NUM_W  = 30;
  localparam int unsigned CHAR_W = 7;
  localparam int unsigned CHUNK_BITS = 5;

  localparam logic signed [LAT_W-1:0] LAT_MAX = 25'sd9000000;
  localparam logic signed [LAT_W-1:0] LAT_MIN = -25'sd9000000;
  localparam logic signed [LNG_W-1:0] LNG_MAX = 26'sd18000000;
  localparam logic signed [LNG_W-1:0] LNG_MIN = -26'sd18000000;

  localparam logic [CHAR_W-1:0] CONT_FLAG = 7'h20;
  localparam logic [CHAR_W-1:0] CHAR_BIAS = 7'd63;
  localparam logic [CHAR_W-1:0] BACKSLASH = 7'd92;

  // req_type codes
  localparam logic REQ_POINT  = 1'b0;
  localparam logic REQ_NUMBER = 1'b1;

  // One queued job: one or two unsigned words to serialize.
  typedef struct packed {
    logic [NUM_W-1:0] word0;
    logic [NUM_W-1:0] word1;
    logic             has_word1;
  } word_pair_t;

endpackage

>>> hw/rtl/pce_front.sv
// Front end: accepts items, saturates coordinates, forms folded deltas.
// Holds the stored previous point. Depends on pce_pkg.
`timescale 1ns / 1ps

module pce_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             req_type_i,
  input  logic                             restart_i,
  input  logic signed [pce_pkg::LAT_W-1:0] lat_e5_i,
  input  logic signed [pce_pkg::LNG_W-1:0] lng_e5_i,
  input  logic [pce_pkg::NUM_W-1:0]        unsigned_value_i,
  output logic                             push_valid_o,
  input  logic                             push_ready_i,
  output pce_pkg::word_pair_t              push_data_o
);

  logic signed [pce_pkg::LAT_W-1:0] prev_lat_q, prev_lat_d;
  logic signed [pce_pkg::LNG_W-1:0] prev_lng_q, prev_lng_d;
  logic signed [pce_pkg::LAT_W-1:0] lat_sat, lat_base;
  logic signed [pce_pkg::LNG_W-1:0] lng_sat, lng_base;
  logic signed [pce_pkg::LAT_W:0]   d_lat;
  logic signed [pce_pkg::LNG_W:0]   d_lng;
  logic [pce_pkg::LAT_W+1:0]        fold_lat;
  logic [pce_pkg::LNG_W+1:0]        fold_lng;
  logic                             accept;

  assign in_stall_o   = !push_ready_i;
  assign push_valid_o = in_valid_i;
  assign accept       = in_valid_i && push_ready_i;

  always_comb begin
    if (lat_e5_i > pce_pkg::LAT_MAX) begin
      lat_sat = pce_pkg::LAT_MAX;
    end else if (lat_e5_i < pce_pkg::LAT_MIN) begin
      lat_sat = pce_pkg::LAT_MIN;
    end else begin
      lat_sat = lat_e5_i;
    end
    if (lng_e5_i > pce_pkg::LNG_MAX) begin
      lng_sat = pce_pkg::LNG_MAX;
    end else if (lng_e5_i < pce_pkg::LNG_MIN) begin
      lng_sat = pce_pkg::LNG_MIN;
    end else begin
      lng_sat = lng_e5_i;
    end
    lat_base = restart_i ? '0 : prev_lat_q;
    lng_base = restart_i ? '0 : prev_lng_q;
    d_lat = {lat_sat[pce_pkg::LAT_W-1], lat_sat} - {lat_base[pce_pkg::LAT_W-1], lat_base};
    d_lng = {lng_sat[pce_pkg::LNG_W-1], lng_sat} - {lng_base[pce_pkg::LNG_W-1], lng_base};
    // zigzag fold: result is non-negative, top bit always clear
    fold_lat = {d_lat, 1'b0} ^ {(pce_pkg::LAT_W+2){d_lat[pce_pkg::LAT_W]}};
    fold_lng = {d_lng, 1'b0} ^ {(pce_pkg::LNG_W+2){d_lng[pce_pkg::LNG_W]}};
  end

  always_comb begin
    prev_lat_d = prev_lat_q;
    prev_lng_d = prev_lng_q;
    unique case (req_type_i)
      pce_pkg::REQ_NUMBER: begin
        push_data_o.word0     = unsigned_value_i;
        push_data_o.word1     = '0;
        push_data_o.has_word1 = 1'b0;
      end
      default: begin
        push_data_o.word0     = pce_pkg::NUM_W'(fold_lat);
        push_data_o.word1     = pce_pkg::NUM_W'(fold_lng);
        push_data_o.has_word1 = 1'b1;
        if (accept) begin
          prev_lat_d = lat_sat;
          prev_lng_d = lng_sat;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_lat_q <= '0;
      prev_lng_q <= '0;
    end else begin
      prev_lat_q <= prev_lat_d;
      prev_lng_q <= prev_lng_d;
    end
  end

  a_prev_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (prev_lat_q <= pce_pkg::LAT_MAX) && (prev_lat_q >= pce_pkg::LAT_MIN) &&
    (prev_lng_q <= pce_pkg::LNG_MAX) && (prev_lng_q >= pce_pkg::LNG_MIN))
    else $error("stored point out of range");

endmodule

>>> hw/rtl/pce_queue.sv
// Two-entry job queue between front end and character serializer.
// Depends on pce_pkg for the job type.
`timescale 1ns / 1ps

module pce_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_valid_i,
  output logic                push_ready_o,
  input  pce_pkg::word_pair_t push_data_i,
  output logic                pop_valid_o,
  input  logic                pop_ready_i,
  output pce_pkg::word_pair_t pop_data_o
);

  pce_pkg::word_pair_t mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       do_push, do_pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      count_q <= count_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= 2'd2)
    else $error("queue count overflow");

endmodule

>>> hw/rtl/pce_back.sv
// Back end: serializes queued words into 5-bit chunk characters, one per cycle
// unless stalled or idle, with optional backslash doubling. Depends on pce_pkg.
`timescale 1ns / 1ps

module pce_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        escape_i,
  input  logic                        pop_valid_i,
  output logic                        pop_ready_o,
  input  pce_pkg::word_pair_t         pop_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [pce_pkg::CHAR_W-1:0]  out_char_o,
  output logic                        last_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EMIT,
    ST_DUP
  } state_e;

  state_e                      state_q, state_d;
  logic [pce_pkg::NUM_W-1:0]   word_q, word_d;
  logic [pce_pkg::NUM_W-1:0]   second_q, second_d;
  logic                        has2_q, has2_d;
  logic                        out_valid_q, out_valid_d;
  logic [pce_pkg::CHAR_W-1:0]  out_char_q, out_char_d;
  logic                        out_last_q, out_last_d;
  logic                        out_ready;
  logic                        final_chunk;
  logic [pce_pkg::CHAR_W-1:0]  chunk_char;
  logic                        advance;

  assign out_ready   = !out_valid_q || !out_stall_i;
  assign pop_ready_o = (state_q == ST_IDLE);
  assign final_chunk = (word_q[pce_pkg::NUM_W-1:pce_pkg::CHUNK_BITS] == '0);
  assign chunk_char  = {2'b00, word_q[pce_pkg::CHUNK_BITS-1:0]} + pce_pkg::CHAR_BIAS;

  always_comb begin
    state_d     = state_q;
    word_d      = word_q;
    second_d    = second_q;
    has2_d      = has2_q;
    out_valid_d = out_valid_q;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;
    advance     = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (out_ready) begin
          out_valid_d = 1'b0;
        end
        if (pop_valid_i) begin
          word_d   = pop_data_i.word0;
          second_d = pop_data_i.word1;
          has2_d   = pop_data_i.has_word1;
          state_d  = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_ready) begin
          out_valid_d = 1'b1;
          if (!final_chunk) begin
            out_char_d = {2'b01, word_q[pce_pkg::CHUNK_BITS-1:0]} + pce_pkg::CHAR_BIAS;
            out_last_d = 1'b0;
            word_d     = word_q >> pce_pkg::CHUNK_BITS;
          end else if (escape_i && (chunk_char == pce_pkg::BACKSLASH)) begin
            // first copy of an escaped backslash; never carries last
            out_char_d = chunk_char;
            out_last_d = 1'b0;
            state_d    = ST_DUP;
          end else begin
            out_char_d = chunk_char;
            out_last_d = !has2_q;
            advance    = 1'b1;
          end
        end
      end
      ST_DUP: begin
        if (out_ready) begin
          out_valid_d = 1'b1;
          out_char_d  = pce_pkg::BACKSLASH;
          out_last_d  = !has2_q;
          advance     = 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (advance) begin
      if (has2_q) begin
        word_d  = second_q;
        has2_d  = 1'b0;
        state_d = ST_EMIT;
      end else begin
        state_d = ST_IDLE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q     <= word_d;
    second_q   <= second_d;
    has2_q     <= has2_d;
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign last_o      = out_last_q;

  a_dup_holds_first_copy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DUP) |-> (out_valid_q && (out_char_q == pce_pkg::BACKSLASH) && !out_last_q))
    else $error("escape copy pending without first backslash in output");

  a_char_printable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_char_q >= pce_pkg::CHAR_BIAS))
    else $error("output character below bias");

  a_dup_needs_escape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_EMIT) && out_ready && final_chunk &&
     (chunk_char == pce_pkg::BACKSLASH) && escape_i) |=> (state_q == ST_DUP))
    else $error("escaped backslash not doubled");

endmodule

>>> hw/rtl/polyline_coordinate_encoder_top.sv
// Polyline coordinate encoder top level: escape register, front end, job queue
// and character serializer. Depends on pce_pkg, pce_front, pce_queue, pce_back.
`timescale 1ns / 1ps

// Usage:
//   Input channel (in_valid_i / in_stall_o): a point (req_type 0) carries
//   lat_e5_i / lng_e5_i, a number (req_type 1) carries unsigned_value_i.
//   A transaction completes when in_valid_i is high and in_stall_o is low.
//   Output channel (out_valid_o / out_stall_i): one encoded character per
//   transaction, last_o set on the final character of each input item.
//   escape_backslash_we_i writes escape_backslash_i; change it only while idle.
// Order: an accepted item is first written into the job queue, then loaded into
//   the serializer, whose output register then holds its first character.
// Throughput: one character per cycle while the output is not stalled, plus an
//   idle step to load each job into the serializer (doubled backslashes add
//   characters). The serializer's single output register sets this pace; a
//   two-entry queue lets the front accept ahead.
// Reset: stored point clears to zero, escaping is enabled, queue and output
//   empty. When the receiver stalls, the held character stays put, the
//   serializer waits, and the queue fills until in_stall_o rises.

module polyline_coordinate_encoder_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              escape_backslash_we_i,
  input  logic                              escape_backslash_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              req_type_i,
  input  logic                              restart_i,
  input  logic signed [pce_pkg::LAT_W-1:0]  lat_e5_i,
  input  logic signed [pce_pkg::LNG_W-1:0]  lng_e5_i,
  input  logic [pce_pkg::NUM_W-1:0]         unsigned_value_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [pce_pkg::CHAR_W-1:0]        out_char_o,
  output logic                              last_o
);

  logic                escape_q;
  logic                push_valid, push_ready;
  pce_pkg::word_pair_t push_data;
  logic                pop_valid, pop_ready;
  pce_pkg::word_pair_t pop_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      escape_q <= 1'b1;
    end else if (escape_backslash_we_i) begin
      escape_q <= escape_backslash_i;
    end
  end

  pce_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .req_type_i       (req_type_i),
    .restart_i        (restart_i),
    .lat_e5_i         (lat_e5_i),
    .lng_e5_i         (lng_e5_i),
    .unsigned_value_i (unsigned_value_i),
    .push_valid_o     (push_valid),
    .push_ready_i     (push_ready),
    .push_data_o      (push_data)
  );

  pce_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  pce_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .escape_i    (escape_q),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_char_o  (out_char_o),
    .last_o      (last_o)
  );

endmodule

>>> sim/tb.sv
// Self-checking testbench for polyline_coordinate_encoder_top: directed and random
// point and number transactions, compared one character at a time against an
// in-bench encoder model. Depends on pce_pkg and the encoder RTL.
`timescale 1ns / 1ps

module tb;

  typedef struct {
    logic                             req;
    logic                             restart;
    logic signed [pce_pkg::LAT_W-1:0] lat;
    logic signed [pce_pkg::LNG_W-1:0] lng;
    logic [pce_pkg::NUM_W-1:0]        num;
  } poly_req_t;

  typedef struct {
    logic [pce_pkg::CHAR_W-1:0] ch;
    logic                       last;
  } poly_char_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic escape_backslash_we_i = 1'b0;
  logic escape_backslash_i = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic req_type_i = pce_pkg::REQ_POINT;
  logic restart_i = 1'b0;
  logic signed [pce_pkg::LAT_W-1:0] lat_e5_i = '0;
  logic signed [pce_pkg::LNG_W-1:0] lng_e5_i = '0;
  logic [pce_pkg::NUM_W-1:0] unsigned_value_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [pce_pkg::CHAR_W-1:0] out_char_o;
  logic last_o;

  // encoder model state
  logic escape_on = 1'b1;
  int prev_lat = 0;
  int prev_lng = 0;
  poly_char_t item_chars[$];
  poly_char_t pending_chars[$];

  int err_cnt = 0;
  int stall_left = 0;
  bit calm = 1'b0;

  polyline_coordinate_encoder_top u_dut (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .escape_backslash_we_i (escape_backslash_we_i),
    .escape_backslash_i    (escape_backslash_i),
    .in_valid_i            (in_valid_i),
    .in_stall_o            (in_stall_o),
    .req_type_i            (req_type_i),
    .restart_i             (restart_i),
    .lat_e5_i              (lat_e5_i),
    .lng_e5_i              (lng_e5_i),
    .unsigned_value_i      (unsigned_value_i),
    .out_valid_o           (out_valid_o),
    .out_stall_i           (out_stall_i),
    .out_char_o            (out_char_o),
    .last_o                (last_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // ---------------- encoder model ----------------

  function automatic void emit_char(logic [pce_pkg::CHAR_W-1:0] c);
    poly_char_t pc;
    pc.ch   = c;
    pc.last = 1'b0;
    item_chars.insert(item_chars.size(), pc);
    if (escape_on && c == pce_pkg::BACKSLASH) item_chars.insert(item_chars.size(), pc);
  endfunction

  function automatic void emit_varint(logic [31:0] v);
    while (v >= 32) begin
      emit_char((pce_pkg::CONT_FLAG | {2'b00, v[4:0]}) + pce_pkg::CHAR_BIAS);
      v = v >> pce_pkg::CHUNK_BITS;
    end
    emit_char({2'b00, v[4:0]} + pce_pkg::CHAR_BIAS);
  endfunction

  function automatic logic [31:0] fold_delta(int d);
    logic [31:0] u;
    u = 32'(d) << 1;
    if (d < 0) u = ~u;
    return u;
  endfunction

  function automatic int saturate(int v, int lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic void encode_item(poly_req_t it);
    int lat;
    int lng;
    item_chars.delete();
    if (it.req == pce_pkg::REQ_NUMBER) begin
      emit_varint({2'b00, it.num});
    end else begin
      lat = saturate(it.lat, int'(pce_pkg::LAT_MAX));
      lng = saturate(it.lng, int'(pce_pkg::LNG_MAX));
      if (it.restart) begin
        prev_lat = 0;
        prev_lng = 0;
      end
      emit_varint(fold_delta(lat - prev_lat));
      emit_varint(fold_delta(lng - prev_lng));
      prev_lat = lat;
      prev_lng = lng;
    end
    item_chars[item_chars.size()-1].last = 1'b1;
    foreach (item_chars[i]) pending_chars.insert(pending_chars.size(), item_chars[i]);
  endfunction

  // ---------------- output side ----------------

  function automatic void check_char(logic [pce_pkg::CHAR_W-1:0] ch, logic lst);
    poly_char_t e;
    if (pending_chars.size() == 0) begin
      $error("unexpected transaction: out_char %0d last %0b", ch, lst);
      err_cnt++;
      return;
    end
    e = pending_chars.pop_front();
    if (ch !== e.ch) begin
      $error("out_char: expected %0d, got %0d", e.ch, ch);
      err_cnt++;
    end
    if (lst !== e.last) begin
      $error("last: expected %0b, got %0b", e.last, lst);
      err_cnt++;
    end
  endfunction

  // mostly short idles, a few long ones
  function automatic int pick_len();
    if ($urandom_range(0, 99) < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic int pick_gap();
    if ($urandom_range(0, 1) == 0) return 0;
    return pick_len();
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) check_char(out_char_o, last_o);
    if (stall_left != 0) stall_left--;
    else if (!calm && $urandom_range(0, 99) < 30) stall_left = pick_len();
    out_stall_i <= (stall_left != 0);
  end

  // ---------------- input side ----------------

  task automatic send_item(input poly_req_t it);
    int gap;
    gap = calm ? 0 : pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    req_type_i       <= it.req;
    restart_i        <= it.restart;
    lat_e5_i         <= it.lat;
    lng_e5_i         <= it.lng;
    unsigned_value_i <= it.num;
    do @(posedge clk_i); while (in_stall_o);
    encode_item(it);
  endtask

  function automatic poly_req_t mk_point(logic rs, int lat, int lng);
    poly_req_t it;
    it.req     = pce_pkg::REQ_POINT;
    it.restart = rs;
    it.lat     = lat[pce_pkg::LAT_W-1:0];
    it.lng     = lng[pce_pkg::LNG_W-1:0];
    it.num     = pce_pkg::NUM_W'($urandom);
    return it;
  endfunction

  function automatic poly_req_t mk_number(logic [31:0] v);
    poly_req_t it;
    it.req     = pce_pkg::REQ_NUMBER;
    it.restart = 1'($urandom);
    it.lat     = pce_pkg::LAT_W'($urandom);
    it.lng     = pce_pkg::LNG_W'($urandom);
    it.num     = v[pce_pkg::NUM_W-1:0];
    return it;
  endfunction

  // drain all outstanding characters, then let the pipeline settle
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_escape(input logic v);
    wait_idle();
    escape_backslash_we_i <= 1'b1;
    escape_backslash_i    <= v;
    @(posedge clk_i);
    escape_backslash_we_i <= 1'b0;
    escape_on = v;
  endtask

  // ---------------- tests ----------------

  task automatic test_numbers();
    send_item(mk_number(0));
    send_item(mk_number(29));          // single chunk that lands on backslash
    send_item(mk_number(31));
    send_item(mk_number(32));
    send_item(mk_number(29 << 25));    // backslash after five chunks
    send_item(mk_number(32'h3fff_ffff));
  endtask

  task automatic test_points();
    send_item(mk_point(1'b1, 0, 0));
    send_item(mk_point(1'b0, 9000000, 18000000));
    send_item(mk_point(1'b0, -9000000, -18000000));
    // beyond the legal range: clamps to the limits
    send_item(mk_point(1'b0, 16777215, 33554431));
    send_item(mk_point(1'b0, -16777216, -33554432));
    send_item(mk_number(5));           // must not disturb the stored point
    send_item(mk_point(1'b0, -9000000, 0));
    send_item(mk_point(1'b1, -15, -15));
    send_item(mk_point(1'b0, -30, -30));
  endtask

  task automatic test_escape_off();
    write_escape(1'b0);
    send_item(mk_number(29));
    send_item(mk_point(1'b1, -15, -15));
    send_item(mk_point(1'b0, -30, 100));
    send_item(mk_point(1'b0, -45, 85));
  endtask

  task automatic test_random(input int n, input logic esc);
    poly_req_t it;
    int r;
    int k;
    int base_lat;
    int base_lng;
    logic [31:0] v;
    write_escape(esc);
    for (int i = 0; i < n; i++) begin
      if (i % 20 == 0) calm = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < 20) begin
        if ($urandom_range(0, 4) == 0) begin
          k = $urandom_range(0, 4);
          v = (32'd29 << (5 * k)) | ($urandom & ((32'd1 << (5 * k)) - 1));
        end else begin
          k = $urandom_range(0, 30);
          v = $urandom & ((32'd1 << k) - 1);
        end
        it = mk_number(v);
      end else begin
        it = mk_point(($urandom_range(0, 9) == 0), 0, 0);
        base_lat = it.restart ? 0 : prev_lat;
        base_lng = it.restart ? 0 : prev_lng;
        if (r < 65) begin
          // small steps, the common case on a real track
          it.lat = pce_pkg::LAT_W'(base_lat + int'($urandom_range(0, 80)) - 40);
          it.lng = pce_pkg::LNG_W'(base_lng + int'($urandom_range(0, 80)) - 40);
        end else if (r < 88) begin
          it.lat = pce_pkg::LAT_W'(int'($urandom_range(0, 18000000)) - 9000000);
          it.lng = pce_pkg::LNG_W'(int'($urandom_range(0, 36000000)) - 18000000);
        end else begin
          it.lat = pce_pkg::LAT_W'($urandom);
          it.lng = pce_pkg::LNG_W'($urandom);
        end
      end
      send_item(it);
    end
    calm = 1'b0;
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_escape(1'b1);
    test_numbers();
    test_points();
    test_escape_off();
    test_random(75, 1'b1);
    test_random(75, 1'b0);
    in_valid_i <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("tb: done, errors");
    $finish;
  end

endmodule
